// ----- rtl/stream_prefetcher_throttled_defines.svh -----
// ----------------------------------------------------------------------------
// stream_prefetcher_throttled_defines.svh
// Assertion macros shared by the stream prefetcher RTL.
// ----------------------------------------------------------------------------
`ifndef STREAM_PREFETCHER_THROTTLED_DEFINES_SVH
`define STREAM_PREFETCHER_THROTTLED_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SPT_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define SPT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SPT_ASSERT(label, expr)
`define SPT_ASSERT_IMPL(label, ante, cons)
`define SPT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/spt_pkg.sv -----
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants of the throttled stream prefetcher.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int ADDR_W     = 64;
  localparam int COUNT_W    = 32;
  localparam int PCT_W      = 7;
  localparam int LEN_W      = 8;
  localparam int DEG_W      = 7;
  localparam int DIR_W      = 2;
  localparam int MISS_W     = 8;
  localparam int PROD_W     = COUNT_W + PCT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LEN_W;

  localparam int DEF_TABLE_ENTRIES = 256;
  localparam int DEF_MAX_DEGREE    = 64;
  localparam int DEF_MAX_DISTANCE  = 4096;
  localparam int DEF_PAGE_SHIFT    = 12;

  localparam int THROTTLE_INIT = 64;
  localparam int PCT_SCALE     = 100;

  localparam logic [PCT_W-1:0] HIGH_PCT_RST   = 7'd70;
  localparam logic [PCT_W-1:0] LOW_PCT_RST    = 7'd50;
  localparam logic [LEN_W-1:0] STREAM_LEN_RST = 8'd64;
  localparam logic [MISS_W-1:0] MISS_MAX      = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_PCT   = 2'd0,
    REG_LOW_PCT    = 2'd1,
    REG_STREAM_LEN = 2'd2
  } cfg_reg_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef struct packed {
    logic              go;
    logic              down;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] prev_address;
  } burst_cmd_t;

endpackage

// ----- rtl/spt_stream_if.sv -----
// ----------------------------------------------------------------------------
// spt_stream_if
// Valid/ready channels for cache accesses and prefetch addresses.
// ----------------------------------------------------------------------------
interface spt_access_if;
  logic                              valid;
  logic                              ready;
  logic [spt_pkg::ADDR_W-1:0]        access_address;
  logic [spt_pkg::ADDR_W-1:0]        instruction_pointer;
  logic                              was_hit;
  logic [spt_pkg::COUNT_W-1:0]       prefetches_issued;
  logic [spt_pkg::COUNT_W-1:0]       prefetches_useful;

  modport source (
    output valid, access_address, instruction_pointer, was_hit,
           prefetches_issued, prefetches_useful,
    input  ready
  );
  modport sink (
    input  valid, access_address, instruction_pointer, was_hit,
           prefetches_issued, prefetches_useful,
    output ready
  );
endinterface

interface spt_prefetch_if;
  logic                       valid;
  logic                       ready;
  logic [spt_pkg::ADDR_W-1:0] prefetch_address;
  logic                       last_of_burst;

  modport source (
    output valid, prefetch_address, last_of_burst,
    input  ready
  );
  modport sink (
    input  valid, prefetch_address, last_of_burst,
    output ready
  );
endinterface

// ----- rtl/stream_prefetcher_throttled.sv -----
// ----------------------------------------------------------------------------
// stream_prefetcher_throttled
// Hit: taken in idle, table not written. Miss: table read, then write-back in
// the lookup state. Burst: one candidate address per cycle unless an in-page
// candidate waits for the prefetch output register, up to degree candidates,
// access held off meanwhile. After reset the stream table is swept before the
// first access transfer; configuration writes are taken during the sweep.
// ----------------------------------------------------------------------------
`include "stream_prefetcher_throttled_defines.svh"

module stream_prefetcher_throttled #(
  parameter int TABLE_ENTRIES = spt_pkg::DEF_TABLE_ENTRIES,
  parameter int MAX_DEGREE    = spt_pkg::DEF_MAX_DEGREE,
  parameter int MAX_DISTANCE  = spt_pkg::DEF_MAX_DISTANCE,
  parameter int PAGE_SHIFT    = spt_pkg::DEF_PAGE_SHIFT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [spt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spt_pkg::CFG_DATA_W-1:0] cfg_data,
  spt_access_if.sink                    access,
  spt_prefetch_if.source                prefetch
);

  localparam int ADDR_W  = spt_pkg::ADDR_W;
  localparam int DIR_W   = spt_pkg::DIR_W;
  localparam int MISS_W  = spt_pkg::MISS_W;
  localparam int PCT_W   = spt_pkg::PCT_W;
  localparam int LEN_W   = spt_pkg::LEN_W;
  localparam int IDX_W   = $clog2(TABLE_ENTRIES);   // power-of-two table
  localparam int TAG_W   = ADDR_W - IDX_W;
  localparam int ENTRY_W = 1 + TAG_W + ADDR_W + DIR_W + MISS_W;
  localparam int DIST_W  = $clog2(MAX_DISTANCE + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t                 state;
  logic [IDX_W-1:0]       clr_idx;
  logic [ADDR_W-1:0]      lk_address;
  logic [ADDR_W-1:0]      lk_ip;

  logic [PCT_W-1:0]       high_threshold_pct;
  logic [PCT_W-1:0]       low_threshold_pct;
  logic [LEN_W-1:0]       stream_length;

  logic                   acc_xfer;
  logic                   burst_busy;
  logic [spt_pkg::DEG_W-1:0] degree;
  logic [DIST_W-1:0]      distance;
  spt_pkg::burst_cmd_t    cmd;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ENTRY_W-1:0]     ram_rdata;

  logic                   ent_valid;
  logic [TAG_W-1:0]       ent_tag;
  logic [ADDR_W-1:0]      ent_last;
  logic [DIR_W-1:0]       ent_dir_raw;
  spt_pkg::dir_t          ent_dir;
  logic [MISS_W-1:0]      ent_miss;

  logic [TAG_W-1:0]       lk_tag;
  logic [ADDR_W-1:0]      diff;
  logic                   down;
  logic                   match;
  logic [MISS_W-1:0]      miss_inc;
  spt_pkg::dir_t          new_dir;
  logic [MISS_W-1:0]      new_miss;
  logic                   trigger;

  assign access.ready = (state == ST_IDLE) && !burst_busy;
  assign acc_xfer     = access.valid && access.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_threshold_pct <= spt_pkg::HIGH_PCT_RST;
      low_threshold_pct  <= spt_pkg::LOW_PCT_RST;
      stream_length      <= spt_pkg::STREAM_LEN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        spt_pkg::REG_HIGH_PCT:   high_threshold_pct <= cfg_data[PCT_W-1:0];
        spt_pkg::REG_LOW_PCT:    low_threshold_pct  <= cfg_data[PCT_W-1:0];
        spt_pkg::REG_STREAM_LEN: stream_length      <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc_xfer && !access.was_hit) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc_xfer) begin
      lk_address <= access.access_address;
      lk_ip      <= access.instruction_pointer;
    end
  end

  spt_throttle #(
    .MAX_DEGREE   (MAX_DEGREE),
    .MAX_DISTANCE (MAX_DISTANCE)
  ) u_throttle (
    .clk      (clk),
    .rst      (rst),
    .update   (acc_xfer),
    .issued   (access.prefetches_issued),
    .useful   (access.prefetches_useful),
    .high_pct (high_threshold_pct),
    .low_pct  (low_threshold_pct),
    .degree   (degree),
    .distance (distance)
  );

  always_comb begin
    {ent_valid, ent_tag, ent_last, ent_dir_raw, ent_miss} = ram_rdata;
    ent_dir  = spt_pkg::dir_t'(ent_dir_raw);
    lk_tag   = lk_ip[ADDR_W-1:IDX_W];
    diff     = lk_address - ent_last;
    down     = diff[ADDR_W-1];
    match    = ent_valid && (ent_tag == lk_tag);
    miss_inc = (ent_miss == spt_pkg::MISS_MAX) ? ent_miss : ent_miss + MISS_W'(1);
    new_dir  = ent_dir;
    new_miss = ent_miss;
    trigger  = 1'b0;
    if (!match) begin
      new_dir  = spt_pkg::DIR_NONE;
      new_miss = MISS_W'(1);
    end else begin
      case (ent_dir) inside
        spt_pkg::DIR_NONE: begin
          new_dir = down ? spt_pkg::DIR_DOWN : spt_pkg::DIR_UP;
        end
        spt_pkg::DIR_UP, spt_pkg::DIR_DOWN: begin
          if (down == (ent_dir == spt_pkg::DIR_DOWN)) begin
            if (miss_inc >= stream_length) begin
              trigger  = 1'b1;
              new_miss = '0;
            end else begin
              new_miss = miss_inc;
            end
          end else begin
            new_miss = '0;
            new_dir  = spt_pkg::DIR_NONE;
          end
        end
        default: begin
          new_miss = '0;
          new_dir  = spt_pkg::DIR_NONE;
        end
      endcase
    end
  end

  always_comb begin
    ram_we    = (state == ST_CLEAR) || (state == ST_LOOKUP);
    ram_waddr = (state == ST_CLEAR) ? clr_idx : lk_ip[IDX_W-1:0];
    ram_wdata = (state == ST_CLEAR) ? '0 :
                {1'b1, lk_tag, lk_address, DIR_W'(new_dir), new_miss};
    cmd.go           = (state == ST_LOOKUP) && trigger;
    cmd.down         = ent_dir == spt_pkg::DIR_DOWN;
    cmd.address      = lk_address;
    cmd.prev_address = ent_last;
  end

  spt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (access.instruction_pointer[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  spt_burst #(
    .MAX_DISTANCE (MAX_DISTANCE),
    .PAGE_SHIFT   (PAGE_SHIFT)
  ) u_burst (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .degree   (degree),
    .distance (distance),
    .busy     (burst_busy),
    .prefetch (prefetch)
  );

  `SPT_ASSERT_NEXT(a_miss_to_lookup, acc_xfer && !access.was_hit, state == ST_LOOKUP)

endmodule

// ----- rtl/spt_ram.sv -----
// ----------------------------------------------------------------------------
// spt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module spt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/spt_throttle.sv -----
// ----------------------------------------------------------------------------
// spt_throttle
// Degree and distance feedback control from prefetch accuracy.
// ----------------------------------------------------------------------------
`include "stream_prefetcher_throttled_defines.svh"

module spt_throttle #(
  parameter int MAX_DEGREE   = spt_pkg::DEF_MAX_DEGREE,
  parameter int MAX_DISTANCE = spt_pkg::DEF_MAX_DISTANCE,
  localparam int DIST_W      = $clog2(MAX_DISTANCE + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         update,
  input  logic [spt_pkg::COUNT_W-1:0]  issued,
  input  logic [spt_pkg::COUNT_W-1:0]  useful,
  input  logic [spt_pkg::PCT_W-1:0]    high_pct,
  input  logic [spt_pkg::PCT_W-1:0]    low_pct,
  output logic [spt_pkg::DEG_W-1:0]    degree,
  output logic [DIST_W-1:0]            distance
);

  localparam int DEG_W     = spt_pkg::DEG_W;
  localparam int PROD_W    = spt_pkg::PROD_W;
  localparam int DEG_INIT  = (spt_pkg::THROTTLE_INIT > MAX_DEGREE) ?
                             MAX_DEGREE : spt_pkg::THROTTLE_INIT;
  localparam int DIST_INIT = (spt_pkg::THROTTLE_INIT > MAX_DISTANCE) ?
                             MAX_DISTANCE : spt_pkg::THROTTLE_INIT;

  logic [PROD_W-1:0] scaled;
  logic [PROD_W-1:0] high_prod;
  logic [PROD_W-1:0] low_prod;
  logic              ge_high;
  logic              ge_low;
  logic [DEG_W:0]    deg_dbl;
  logic [DEG_W-1:0]  deg_half;
  logic [DIST_W:0]   dist_dbl;
  logic [DIST_W-1:0] dist_half;
  logic [DEG_W-1:0]  degree_next;
  logic [DIST_W-1:0] distance_next;

  always_comb begin
    scaled    = PROD_W'(useful) * PROD_W'(spt_pkg::PCT_SCALE);
    high_prod = PROD_W'(high_pct) * PROD_W'(issued);
    low_prod  = PROD_W'(low_pct) * PROD_W'(issued);
    ge_high   = scaled >= high_prod;
    ge_low    = scaled >= low_prod;
    deg_dbl   = {degree, 1'b0};
    deg_half  = degree >> 1;
    dist_dbl  = {distance, 1'b0};
    dist_half = distance >> 1;
    degree_next   = DEG_W'(1);
    distance_next = DIST_W'(1);
    if (issued != '0) begin
      if (ge_high) begin
        degree_next   = (deg_dbl > (DEG_W+1)'(MAX_DEGREE)) ?
                        DEG_W'(MAX_DEGREE) : deg_dbl[DEG_W-1:0];
        distance_next = (dist_dbl > (DIST_W+1)'(MAX_DISTANCE)) ?
                        DIST_W'(MAX_DISTANCE) : dist_dbl[DIST_W-1:0];
      end else if (ge_low) begin
        degree_next   = (deg_half == '0) ? DEG_W'(1) : deg_half;
        distance_next = (dist_half == '0) ? DIST_W'(1) : dist_half;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      degree   <= DEG_W'(DEG_INIT);
      distance <= DIST_W'(DIST_INIT);
    end else if (update) begin
      degree   <= degree_next;
      distance <= distance_next;
    end
  end

  `SPT_ASSERT(a_degree_range, degree != '0 && degree <= DEG_W'(MAX_DEGREE))
  `SPT_ASSERT(a_distance_range, distance != '0 && distance <= DIST_W'(MAX_DISTANCE))

endmodule

// ----- rtl/spt_burst.sv -----
// ----------------------------------------------------------------------------
// spt_burst
// Prefetch burst generator with an output register on the prefetch channel.
// ----------------------------------------------------------------------------
`include "stream_prefetcher_throttled_defines.svh"

module spt_burst #(
  parameter int MAX_DISTANCE = spt_pkg::DEF_MAX_DISTANCE,
  parameter int PAGE_SHIFT   = spt_pkg::DEF_PAGE_SHIFT,
  localparam int DIST_W      = $clog2(MAX_DISTANCE + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  spt_pkg::burst_cmd_t        cmd,
  input  logic [spt_pkg::DEG_W-1:0]  degree,
  input  logic [DIST_W-1:0]          distance,
  output logic                       busy,
  spt_prefetch_if.source             prefetch
);

  localparam int ADDR_W = spt_pkg::ADDR_W;
  localparam int DEG_W  = spt_pkg::DEG_W;
  localparam int PAGE_W = ADDR_W - PAGE_SHIFT;

  logic              active;
  logic [ADDR_W-1:0] step;
  logic [ADDR_W-1:0] cand;
  logic [ADDR_W-1:0] cand2;
  logic [PAGE_W-1:0] page;
  logic [DEG_W-1:0]  cnt;

  logic [ADDR_W-1:0] step_init;
  logic              kept;
  logic              fin;
  logic              tail;
  logic              slot;
  logic              adv;
  logic              load;

  always_comb begin
    step_init = cmd.down ? (ADDR_W'(0) - ADDR_W'(distance)) : ADDR_W'(distance);
    kept = cand[ADDR_W-1:PAGE_SHIFT] == page;
    fin  = cnt == (degree - DEG_W'(1));
    // candidates in the page form one contiguous run
    tail = fin || (cand2[ADDR_W-1:PAGE_SHIFT] != page);
    slot = !prefetch.valid || prefetch.ready;
    adv  = active && (!kept || slot);
    load = adv && kept;
  end

  assign busy = active;

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      prefetch.valid <= 1'b0;
    end else begin
      if (cmd.go) begin
        active <= 1'b1;
      end else if (adv && (fin || (kept && tail))) begin
        active <= 1'b0;
      end
      if (prefetch.valid && prefetch.ready) begin
        prefetch.valid <= 1'b0;
      end
      if (load) begin
        prefetch.valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      step  <= step_init;
      cand  <= cmd.address + step_init;
      cand2 <= cmd.address + {step_init[ADDR_W-2:0], 1'b0};
      page  <= cmd.prev_address[ADDR_W-1:PAGE_SHIFT];
      cnt   <= '0;
    end else if (adv) begin
      cand  <= cand2;
      cand2 <= cand2 + step;
      cnt   <= cnt + DEG_W'(1);
    end
    if (load) begin
      prefetch.prefetch_address <= cand;
      prefetch.last_of_burst    <= tail;
    end
  end

  `SPT_ASSERT_IMPL(a_go_when_idle, cmd.go, !active)
  `SPT_ASSERT_IMPL(a_cnt_below_degree, active, cnt < degree)
  `SPT_ASSERT_NEXT(a_go_starts_burst, cmd.go, active)

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: throttled stream prefetcher testbench
// Drives cache accesses into the prefetcher, tracks its throttle and stream
// table state in a scoreboard, and checks every prefetch transfer in order.
// Runs directed streams first, then random stream traffic under several
// threshold settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb;

  localparam int ADDR_W       = spt_pkg::ADDR_W;
  localparam int COUNT_W      = spt_pkg::COUNT_W;
  localparam int PCT_W        = spt_pkg::PCT_W;
  localparam int LEN_W        = spt_pkg::LEN_W;
  localparam int MISS_W       = spt_pkg::MISS_W;
  localparam int CFG_IDX_W    = spt_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = spt_pkg::CFG_DATA_W;
  localparam int TABLE_SIZE   = spt_pkg::DEF_TABLE_ENTRIES;
  localparam int IDX_W        = $clog2(spt_pkg::DEF_TABLE_ENTRIES);
  localparam int PAGE_SH      = spt_pkg::DEF_PAGE_SHIFT;
  localparam int STREAMS      = 4;
  localparam int SETTLE       = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int WATCHDOG     = 4000;

  typedef struct {
    logic [ADDR_W-1:0]  access_address;
    logic [ADDR_W-1:0]  instruction_pointer;
    logic               was_hit;
    logic [COUNT_W-1:0] prefetches_issued;
    logic [COUNT_W-1:0] prefetches_useful;
  } access_t;

  typedef struct {
    logic [ADDR_W-1:0] prefetch_address;
    logic              last_of_burst;
  } prefetch_t;

  class prefetch_scoreboard;
    logic [PCT_W-1:0]        high_pct;
    logic [PCT_W-1:0]        low_pct;
    logic [LEN_W-1:0]        burst_len;
    int unsigned             degree;
    int unsigned             distance;
    bit                      row_valid [TABLE_SIZE];
    logic [ADDR_W-IDX_W-1:0] row_tag   [TABLE_SIZE];
    logic [ADDR_W-1:0]       row_last  [TABLE_SIZE];
    spt_pkg::dir_t           row_dir   [TABLE_SIZE];
    logic [MISS_W-1:0]       row_count [TABLE_SIZE];
    prefetch_t               pending_q [$];
    int                      mismatches;

    function new();
      high_pct   = spt_pkg::HIGH_PCT_RST;
      low_pct    = spt_pkg::LOW_PCT_RST;
      burst_len  = spt_pkg::STREAM_LEN_RST;
      degree     = spt_pkg::THROTTLE_INIT;
      distance   = spt_pkg::THROTTLE_INIT;
      mismatches = 0;
      foreach (row_valid[i]) row_valid[i] = 1'b0;
    endfunction

    function void set_config(logic [PCT_W-1:0] hi, logic [PCT_W-1:0] lo,
                             logic [LEN_W-1:0] len);
      high_pct  = hi;
      low_pct   = lo;
      burst_len = len;
    endfunction

    function int unsigned throttle(int unsigned v, int unsigned vmax,
                                   logic [COUNT_W-1:0] issued,
                                   logic [COUNT_W-1:0] useful);
      logic [63:0] scaled;
      if (issued == 0) return 1;
      scaled = 64'(useful) * 64'(spt_pkg::PCT_SCALE);
      if (scaled >= 64'(high_pct) * 64'(issued)) return (2 * v > vmax) ? vmax : 2 * v;
      if (scaled >= 64'(low_pct) * 64'(issued)) return (v / 2 < 1) ? 1 : v / 2;
      return 1;
    endfunction

    function void note_access(access_t a);
      logic [IDX_W-1:0]        idx;
      logic [ADDR_W-IDX_W-1:0] tg;
      logic [ADDR_W-1:0]       lst;
      logic [ADDR_W-1:0]       diff;
      logic [ADDR_W-1:0]       stride;
      logic [ADDR_W-1:0]       nxt;
      logic                    down;
      spt_pkg::dir_t           d;
      prefetch_t               p;
      logic [ADDR_W-1:0]       kept [$];
      degree   = throttle(degree, spt_pkg::DEF_MAX_DEGREE, a.prefetches_issued,
                          a.prefetches_useful);
      distance = throttle(distance, spt_pkg::DEF_MAX_DISTANCE, a.prefetches_issued,
                          a.prefetches_useful);
      if (a.was_hit) return;
      idx = a.instruction_pointer[IDX_W-1:0];
      tg  = a.instruction_pointer[ADDR_W-1:IDX_W];
      if (!row_valid[idx] || row_tag[idx] != tg) begin
        row_valid[idx] = 1'b1;
        row_tag[idx]   = tg;
        row_last[idx]  = a.access_address;
        row_dir[idx]   = spt_pkg::DIR_NONE;
        row_count[idx] = 1;
        return;
      end
      lst  = row_last[idx];
      diff = a.access_address - lst;
      down = diff[ADDR_W-1];
      d    = row_dir[idx];
      if (d == spt_pkg::DIR_NONE) begin
        row_dir[idx] = down ? spt_pkg::DIR_DOWN : spt_pkg::DIR_UP;
      end else if ((!down && d == spt_pkg::DIR_UP) || (down && d == spt_pkg::DIR_DOWN)) begin
        if (row_count[idx] != spt_pkg::MISS_MAX) row_count[idx] = row_count[idx] + 1;
        if (row_count[idx] >= burst_len) begin
          stride = 64'(distance);
          if (d == spt_pkg::DIR_DOWN) stride = -stride;
          nxt = a.access_address + stride;
          for (int i = 0; i < degree; i++) begin
            if (nxt[ADDR_W-1:PAGE_SH] == lst[ADDR_W-1:PAGE_SH])
              kept.insert(kept.size(), nxt);
            nxt = nxt + stride;
          end
          foreach (kept[k]) begin
            p.prefetch_address = kept[k];
            p.last_of_burst    = (k == kept.size() - 1) ? 1'b1 : 1'b0;
            pending_q.insert(pending_q.size(), p);
          end
          row_count[idx] = 0;
        end
      end else begin
        row_count[idx] = 0;
        row_dir[idx]   = spt_pkg::DIR_NONE;
      end
      row_last[idx] = a.access_address;
    endfunction

    function void check_result(logic [ADDR_W-1:0] addr, logic lob);
      prefetch_t e;
      if (pending_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected prefetch transfer: addr %h last %b", addr, lob);
        mismatches++;
        return;
      end
      e = pending_q[0];
      pending_q.delete(0);
      if (addr !== e.prefetch_address || lob !== e.last_of_burst) begin
        if (mismatches < 10)
          $display("prefetch mismatch: expected addr %h last %b, got addr %h last %b",
                   e.prefetch_address, e.last_of_burst, addr, lob);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  spt_access_if   acc ();
  spt_prefetch_if pf ();

  stream_prefetcher_throttled dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .access    (acc),
    .prefetch  (pf)
  );

  prefetch_scoreboard sb = new();

  int src_idle       = 0;
  int sink_stall     = 0;
  int hold_reqs      = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int stalled_cycles = 0;

  logic [ADDR_W-1:0] strm_ip     [STREAMS];
  logic [ADDR_W-1:0] strm_addr   [STREAMS];
  logic [ADDR_W-1:0] strm_stride [STREAMS];

  always #10 clk = ~clk;

  // prefetch sink: check, then pick next ready (long hold-off on request)
  always @(posedge clk) begin
    if (pf.valid === 1'b1 && pf.ready === 1'b1)
      sb.check_result(pf.prefetch_address, pf.last_of_burst);
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pf.ready <= 1'b0;
    end else begin
      pf.ready <= ($urandom_range(99) >= sink_stall);
    end
  end

  always @(posedge clk) begin
    if ((acc.valid && acc.ready) || (pf.valid && pf.ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG) begin
        $display("** stream_prefetcher_throttled: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic [ADDR_W-1:0] pick_stride();
    logic [ADDR_W-1:0] mag;
    mag = 64'd8 << $urandom_range(4);
    if ($urandom_range(9) == 0) mag = '0;
    return $urandom_range(1) ? mag : -mag;
  endfunction

  function automatic void new_stream(int k);
    strm_ip[k]     = {$urandom, $urandom};
    strm_addr[k]   = {$urandom, $urandom};
    strm_stride[k] = pick_stride();
  endfunction

  function automatic access_t gen_item();
    access_t a;
    int      k;
    int      r;
    int      pct;
    r = $urandom_range(99);
    k = $urandom_range(STREAMS - 1);
    a.was_hit = 1'b0;
    if (r < 70) begin
      if ($urandom_range(19) == 0) strm_stride[k] = -strm_stride[k];
      strm_addr[k] = strm_addr[k] + strm_stride[k];
      a.access_address      = strm_addr[k];
      a.instruction_pointer = strm_ip[k];
      a.was_hit             = ($urandom_range(9) == 0);
    end else if (r < 90) begin
      a.access_address      = {$urandom, $urandom};
      a.instruction_pointer = {$urandom, $urandom};
      a.was_hit             = (r < 80);
    end else begin
      new_stream(k);
      a.access_address      = strm_addr[k];
      a.instruction_pointer = strm_ip[k];
    end
    r = $urandom_range(9);
    if (r == 0) begin
      a.prefetches_issued = '0;
      a.prefetches_useful = $urandom;
    end else if (r == 1) begin
      a.prefetches_issued = $urandom;
      a.prefetches_useful = $urandom;
    end else begin
      a.prefetches_issued = $urandom_range(1) ? $urandom : $urandom_range(1, 1000);
      pct = ($urandom_range(2) != 0) ? $urandom_range(75, 130) : $urandom_range(0, 74);
      a.prefetches_useful = 32'((64'(a.prefetches_issued) * 64'(pct)) / 64'd100);
    end
    return a;
  endfunction

  task automatic send_access(access_t a);
    while ($urandom_range(99) < src_idle) begin
      acc.valid <= 1'b0;
      @(posedge clk);
    end
    acc.valid               <= 1'b1;
    acc.access_address      <= a.access_address;
    acc.instruction_pointer <= a.instruction_pointer;
    acc.was_hit             <= a.was_hit;
    acc.prefetches_issued   <= a.prefetches_issued;
    acc.prefetches_useful   <= a.prefetches_useful;
    do @(posedge clk); while (acc.ready !== 1'b1);
    sb.note_access(a);
  endtask

  task automatic send_fields(logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] ip, logic hit,
                             logic [COUNT_W-1:0] issued, logic [COUNT_W-1:0] useful);
    access_t a;
    a = '{addr, ip, hit, issued, useful};
    send_access(a);
  endtask

  task automatic set_config(logic [PCT_W-1:0] hi, logic [PCT_W-1:0] lo,
                            logic [LEN_W-1:0] len);
    cfg_write <= 1'b1;
    cfg_index <= spt_pkg::REG_HIGH_PCT;
    cfg_data  <= {1'b0, hi};
    @(posedge clk);
    cfg_index <= spt_pkg::REG_LOW_PCT;
    cfg_data  <= {1'b0, lo};
    @(posedge clk);
    cfg_index <= spt_pkg::REG_STREAM_LEN;
    cfg_data  <= len;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_config(hi, lo, len);
  endtask

  task automatic drain();
    acc.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(int src, int sink, logic [PCT_W-1:0] hi, logic [PCT_W-1:0] lo,
                           logic [LEN_W-1:0] len, int n, bit press);
    src_idle = src;
    sink_stall <= sink;
    set_config(hi, lo, len);
    for (int i = 0; i < n; i++) begin
      if (press && i == 20) hold_reqs <= hold_reqs + 1;
      send_access(gen_item());
    end
    drain();
  endtask

  initial begin
    logic [ADDR_W-1:0] ip_a;
    logic [ADDR_W-1:0] ip_b;
    ip_a = 64'h0000_0000_0040_0012;
    ip_b = 64'h0123_4567_89AB_CD05;
    clk                     = 1'b0;
    rst                     = 1'b1;
    cfg_write               = 1'b0;
    cfg_index               = spt_pkg::REG_HIGH_PCT;
    cfg_data                = '0;
    acc.valid               = 1'b0;
    acc.access_address      = '0;
    acc.instruction_pointer = '0;
    acc.was_hit             = 1'b0;
    acc.prefetches_issued   = '0;
    acc.prefetches_useful   = '0;
    pf.ready                = 1'b0;
    for (int k = 0; k < STREAMS; k++) new_stream(k);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    set_config(7'd70, 7'd50, 8'd2);

    // nothing issued, allocate, zero delta resolves as up
    send_fields(64'h1000, ip_a, 1'b0, 32'd0, 32'd5);
    send_fields(64'h1000, ip_a, 1'b0, 32'd100, 32'd100);
    send_fields(64'h1040, ip_a, 1'b0, 32'd100, 32'd100);
    send_fields(64'h1080, ip_a, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(64'h10C0, ip_a, 1'b0, 32'd100, 32'd100);
    // hit only throttles
    send_fields(64'h5000, ip_a, 1'b1, 32'd100, 32'd60);
    // direction break, then a down stream whose burst runs below address zero
    send_fields(64'h1000, ip_a, 1'b0, 32'd100, 32'd100);
    send_fields(64'h0FF0, ip_a, 1'b0, 32'd100, 32'd100);
    send_fields(64'h0FE0, ip_a, 1'b0, 32'd100, 32'd100);
    send_fields(64'h0FD0, ip_a, 1'b0, 32'd100, 32'd100);
    // same index, different tag
    send_fields(64'h2000, ip_a + 64'd256, 1'b0, 32'd100, 32'd20);
    // top of address space, thresholds hit exactly, burst wraps out of page
    send_fields(64'hFFFF_FFFF_FFFF_FF00, '1, 1'b0, 32'd100, 32'd70);
    send_fields(64'hFFFF_FFFF_FFFF_FF40, '1, 1'b0, 32'd100, 32'd50);
    send_fields(64'hFFFF_FFFF_FFFF_FF80, '1, 1'b0, 32'd1, 32'hFFFF_FFFF);
    send_fields(64'hFFFF_FFFF_FFFF_FFC0, '1, 1'b0, 32'd100, 32'd100);
    send_fields(64'hFFFF_FFFF_FFFF_FFF8, '1, 1'b0, 32'd100, 32'd100);
    send_fields(64'h7000, ip_b, 1'b0, 32'hFFFF_FFFF, 32'd0);
    send_fields(64'hDEAD_BEEF_0000_0000, 64'h1234, 1'b1, 32'd0, 32'd0);
    drain();

    run_phase(0, 0, 7'd70, 7'd50, 8'd3, 70, 1'b1);
    run_phase(50, 0, 7'd127, 7'd0, 8'd1, 50, 1'b0);
    run_phase(0, 50, 7'd0, 7'd127, 8'd255, 25, 1'b0);
    run_phase(25, 25, 7'd50, 7'd70, 8'd0, 50, 1'b0);
    run_phase(0, 0, 7'd100, 7'd0, 8'd4, 35, 1'b0);

    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("** stream_prefetcher_throttled: PASSED **");
    else
      $display("** stream_prefetcher_throttled: FAILED **");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/spt_pkg.sv
rtl/spt_stream_if.sv
rtl/spt_ram.sv
rtl/spt_throttle.sv
rtl/spt_burst.sv
rtl/stream_prefetcher_throttled.sv
tb/tb.sv
